// ----- rtl/csmg_pkg.sv -----
// Shared constants for the channel select mask generator.
package csmg_pkg;

  // Field and register widths.
  localparam int SLOT_W    = 16;
  localparam int KO_W      = 4;
  localparam int DIM_W     = 7;
  localparam int CHAN_W    = 12;
  localparam int COUNT_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  // Derived geometry widths.
  localparam int ROW_LEN_W   = KO_W + DIM_W;        // ko * wo
  localparam int PLANE_LEN_W = 2 * ROW_LEN_W;       // ko * ho * ko * wo
  localparam int KK_W        = 2 * KO_W;            // ko * ko
  localparam int HI_W        = KK_W + DIM_W;        // ko * ko * plane
  localparam int LO_W        = 2 * KO_W;            // ko * (row mod ko) + col mod ko

  // Largest slot count the layout may use.
  localparam int MAX_SLOTS = 65536;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_FACTOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CHANNEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT     = 3'd5;

endpackage

// ----- rtl/csmg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a static divisor.
module csmg_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 22,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic [TAG_W-1:0] tag_out
);

  // Stage i holds the partial remainder and a word whose upper bits are the
  // dividend bits still to come and whose lower bits are quotient bits so far.
  logic             valid [1:NUM_W];
  logic [DEN_W-1:0] rem_s [1:NUM_W];
  logic [NUM_W-1:0] q_s   [1:NUM_W];
  logic [TAG_W-1:0] tag_s [1:NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             valid_p;
    logic [DEN_W-1:0] rem_p;
    logic [NUM_W-1:0] q_p;
    logic [TAG_W-1:0] tag_p;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign valid_p = in_valid;
      assign rem_p   = '0;
      assign q_p     = num;
      assign tag_p   = tag_in;
    end else begin : g_rest
      assign valid_p = valid[i];
      assign rem_p   = rem_s[i];
      assign q_p     = q_s[i];
      assign tag_p   = tag_s[i];
    end

    assign trial = {rem_p, q_p[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_s[i+1]   <= {q_p[NUM_W-2:0], ge};
        tag_s[i+1] <= tag_p;
      end
    end
  end

  assign out_valid = valid[NUM_W];
  assign quo       = q_s[NUM_W];
  assign rem       = rem_s[NUM_W];
  assign tag_out   = tag_s[NUM_W];

endmodule

// ----- rtl/channel_select_mask_generator_unit.sv -----
// Top level of the channel select mask generator: config registers and slot pipeline.
//
// The block classifies one slot of a multiplexed-packed ciphertext layout per
// request and reports whether the slot carries the configured target channel.
// Requests enter on the s_axis channel (slot index in tdata) and results leave
// on the m_axis channel (slot echo and selected flag in tdata), one result per
// request and in request order.
// Geometry and the target are written through the cfg port while the block is
// idle; the derived lengths (ko*wo, ko*ho*ko*wo, ko*ko) are registered, the plane
// length from registered ko*ho and ko*wo, which the front of the pipeline covers
// before any divider reads them. The slot is split by four chained pipelined
// dividers (plane, row and column, row mod ko, column mod ko), each producing one
// quotient bit per stage, so a request passes 16 + 16 + 16 + 11 divider stages
// plus four other register stages on its way to a valid result.
// Throughput is one request per cycle: every stage advances together whenever
// the output register is empty or being taken.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits and returns the registers to a 1x1
// layout with one plane, target channel 0 and a slot count of 65536.
module channel_select_mask_generator_unit #(
  parameter int MAX_SLOTS = csmg_pkg::MAX_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request channel. tdata: slot_index[15:0].
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [csmg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Result channel. tdata: slot_echo[15:0], selected[16], zeros above.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [csmg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [csmg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csmg_pkg::CFG_W-1:0]         cfg_data
);

  localparam int SLOT_W = csmg_pkg::SLOT_W;
  localparam int KO_W   = csmg_pkg::KO_W;
  localparam int DIM_W  = csmg_pkg::DIM_W;
  localparam int RL_W   = csmg_pkg::ROW_LEN_W;
  localparam int PL_W   = csmg_pkg::PLANE_LEN_W;
  localparam int T1_W   = SLOT_W + 1;
  localparam int T2_W   = SLOT_W + 1 + DIM_W;
  localparam int T3_W   = T2_W + RL_W;
  localparam int T4_W   = T2_W + KO_W;

  // Configuration registers.
  logic [KO_W-1:0]              group_factor;
  logic [DIM_W-1:0]             out_height;
  logic [DIM_W-1:0]             out_width;
  logic [DIM_W-1:0]             plane_count;
  logic [csmg_pkg::CHAN_W-1:0]  target_channel;
  logic [csmg_pkg::COUNT_W-1:0] slot_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_factor   <= KO_W'(1);
      out_height     <= DIM_W'(1);
      out_width      <= DIM_W'(1);
      plane_count    <= DIM_W'(1);
      target_channel <= '0;
      slot_count     <= csmg_pkg::COUNT_W'(csmg_pkg::MAX_SLOTS);
    end else if (cfg_we) begin
      case (cfg_index)
        csmg_pkg::REG_GROUP_FACTOR:   group_factor   <= cfg_data[KO_W-1:0];
        csmg_pkg::REG_OUT_HEIGHT:     out_height     <= cfg_data[DIM_W-1:0];
        csmg_pkg::REG_OUT_WIDTH:      out_width      <= cfg_data[DIM_W-1:0];
        csmg_pkg::REG_PLANE_COUNT:    plane_count    <= cfg_data[DIM_W-1:0];
        csmg_pkg::REG_TARGET_CHANNEL: target_channel <= cfg_data[csmg_pkg::CHAN_W-1:0];
        csmg_pkg::REG_SLOT_COUNT:     slot_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derived geometry, recomputed every cycle. The plane length needs two
  // multiplications, so it takes a second register level.
  logic [RL_W-1:0]              row_len;
  logic [RL_W-1:0]              ko_ho;
  logic [csmg_pkg::KK_W-1:0]    ko_sq;
  logic [PL_W-1:0]              plane_len;

  always_ff @(posedge clk) begin
    row_len   <= RL_W'(group_factor) * RL_W'(out_width);
    ko_ho     <= RL_W'(group_factor) * RL_W'(out_height);
    ko_sq     <= csmg_pkg::KK_W'(group_factor) * csmg_pkg::KK_W'(group_factor);
    plane_len <= PL_W'(ko_ho) * PL_W'(row_len);
  end

  // A layout with any zero dimension or no planes selects nothing.
  logic zero_geom;
  assign zero_geom = (group_factor == '0) || (out_height == '0) ||
                     (out_width == '0) || (plane_count == '0);

  // The whole pipeline moves together unless a result is waiting.
  logic en;
  logic sel_next;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Front stages: capture the slot, then flag out-of-range slots.
  logic              s0_valid;
  logic [SLOT_W-1:0] s0_slot;
  logic              s1_valid;
  logic [SLOT_W-1:0] s1_slot;
  logic              s1_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_axis_tvalid;
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_slot <= s_axis_tdata[SLOT_W-1:0];
      s1_slot <= s0_slot;
      s1_bad  <= zero_geom ||
                 ({1'b0, s0_slot} >= slot_count) ||
                 (32'(s0_slot) >= MAX_SLOTS);
    end
  end

  // Plane and remainder within the plane.
  logic              d1_valid;
  logic [SLOT_W-1:0] d1_quo;
  logic [PL_W-1:0]   d1_rem;
  logic [T1_W-1:0]   d1_tag;

  csmg_div #(.NUM_W(SLOT_W), .DEN_W(PL_W), .TAG_W(T1_W)) u_div_plane (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .num       (s1_slot),
    .den       (plane_len),
    .tag_in    ({s1_slot, s1_bad}),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .rem       (d1_rem),
    .tag_out   (d1_tag)
  );

  // A plane past the plane count is never selected. When it is not, the
  // plane fits the plane count width.
  logic bad1;
  assign bad1 = d1_tag[0] || (d1_quo >= SLOT_W'(plane_count));

  // Row and column within the plane.
  logic              d2_valid;
  logic [SLOT_W-1:0] d2_quo;
  logic [RL_W-1:0]   d2_rem;
  logic [T2_W-1:0]   d2_tag;

  csmg_div #(.NUM_W(SLOT_W), .DEN_W(RL_W), .TAG_W(T2_W)) u_div_row (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_valid),
    .num       (d1_rem[SLOT_W-1:0]),
    .den       (row_len),
    .tag_in    ({d1_tag[T1_W-1:1], bad1, d1_quo[DIM_W-1:0]}),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .rem       (d2_rem),
    .tag_out   (d2_tag)
  );

  // Row modulo ko; the column rides along in the tag.
  logic            d3_valid;
  logic [KO_W-1:0] d3_rem;
  logic [T3_W-1:0] d3_tag;

  csmg_div #(.NUM_W(SLOT_W), .DEN_W(KO_W), .TAG_W(T3_W)) u_div_row_mod (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d2_valid),
    .num       (d2_quo),
    .den       (group_factor),
    .tag_in    ({d2_tag, d2_rem}),
    .out_valid (d3_valid),
    .quo       (),
    .rem       (d3_rem),
    .tag_out   (d3_tag)
  );

  // Column modulo ko.
  logic            d4_valid;
  logic [KO_W-1:0] d4_rem;
  logic [T4_W-1:0] d4_tag;

  csmg_div #(.NUM_W(RL_W), .DEN_W(KO_W), .TAG_W(T4_W)) u_div_col_mod (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d3_valid),
    .num       (d3_tag[RL_W-1:0]),
    .den       (group_factor),
    .tag_in    ({d3_tag[T3_W-1:RL_W], d3_rem}),
    .out_valid (d4_valid),
    .quo       (),
    .rem       (d4_rem),
    .tag_out   (d4_tag)
  );

  // Channel index parts: ko*ko*plane and ko*(row mod ko) + col mod ko.
  logic                      m_valid;
  logic [SLOT_W-1:0]         m_slot;
  logic                      m_bad;
  logic [csmg_pkg::HI_W-1:0] m_hi;
  logic [csmg_pkg::LO_W-1:0] m_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_slot <= d4_tag[T4_W-1:T4_W-SLOT_W];
      m_bad  <= d4_tag[KO_W+DIM_W];
      m_hi   <= csmg_pkg::HI_W'(ko_sq) * csmg_pkg::HI_W'(d4_tag[KO_W+DIM_W-1:KO_W]);
      m_lo   <= csmg_pkg::LO_W'(group_factor) * csmg_pkg::LO_W'(d4_tag[KO_W-1:0]) +
                csmg_pkg::LO_W'(d4_rem);
    end
  end

  // Final compare against the target, straight into the output register.
  assign sel_next = !m_bad &&
                    ((SLOT_W'(m_hi) + SLOT_W'(m_lo)) == SLOT_W'(target_channel));

  logic [SLOT_W-1:0] out_slot;
  logic              out_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_slot <= m_slot;
      out_sel  <= sel_next;
    end
  end

  assign m_axis_tdata = {(csmg_pkg::OUT_DATA_W - SLOT_W - 1)'(0), out_sel, out_slot};

endmodule

// ----- tb/tb_channel_select_mask_generator_unit.sv -----
// Self-checking testbench for the channel select mask generator: directed and random slots.
module tb_channel_select_mask_generator_unit;

  localparam int SLOT_W     = csmg_pkg::SLOT_W;
  localparam int KO_W       = csmg_pkg::KO_W;
  localparam int DIM_W      = csmg_pkg::DIM_W;
  localparam int CHAN_W     = csmg_pkg::CHAN_W;
  localparam int COUNT_W    = csmg_pkg::COUNT_W;
  localparam int CFG_IDX_W  = csmg_pkg::CFG_IDX_W;
  localparam int CFG_W      = csmg_pkg::CFG_W;
  localparam int IN_DATA_W  = csmg_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = csmg_pkg::OUT_DATA_W;
  localparam int MAX_SLOTS  = csmg_pkg::MAX_SLOTS;

  // Indexes past the end of the register list. Writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Length of the one long receiver hold-off. It is far beyond the pipeline
  // depth, so the block fills completely and has to drop s_axis_tready.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any accepted request on either side before the run is declared hung.
  // The worst correct case is the long hold-off plus a few cycles.
  localparam int QUIET_LIMIT = 2000;
  // Wait after the last expected result, so that a stray extra result still shows up.
  localparam int DRAIN_CYCLES = 80;

  // One expected result: the slot it refers to and the predicted mask bit.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              selected;
  } slot_verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // The testbench's own copy of the layout registers, at the block's widths.
  logic [KO_W-1:0]    ko_reg = 4'd1;
  logic [DIM_W-1:0]   height_reg = 7'd1;
  logic [DIM_W-1:0]   width_reg = 7'd1;
  logic [DIM_W-1:0]   planes_reg = 7'd1;
  logic [CHAN_W-1:0]  target_reg = '0;
  logic [COUNT_W-1:0] count_reg = 17'd65536;

  // Slots waiting to be offered, and mask bits predicted for accepted slots.
  logic [SLOT_W-1:0] pending_slots[$];
  slot_verdict_t     verdicts_due[$];

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  long_hold = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  bit  sender_steady = 1'b0;
  bit  receiver_steady = 1'b0;

  channel_select_mask_generator_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Mask bit for one slot under the current layout. The slot splits into a plane of
  // ko*ho*ko*wo slots, then a row of ko*wo slots and a column; the channel is
  // ko*ko*plane + ko*(row mod ko) + column mod ko.
  function automatic logic predict_selected(input logic [SLOT_W-1:0] slot);
    int unsigned ko;
    int unsigned limit;
    int unsigned row_len;
    int unsigned plane_len;
    int unsigned plane;
    int unsigned rem;
    ko = 32'(ko_reg);
    // Slot counts above the layout maximum are clipped to it.
    limit = (count_reg > MAX_SLOTS) ? MAX_SLOTS : 32'(count_reg);
    if (32'(slot) >= limit) return 1'b0;
    // An empty geometry or no planes at all selects nothing.
    if (ko == 0 || height_reg == 0 || width_reg == 0 || planes_reg == 0) return 1'b0;
    row_len = ko * 32'(width_reg);
    plane_len = ko * 32'(height_reg) * row_len;
    plane = 32'(slot) / plane_len;
    if (plane >= 32'(planes_reg)) return 1'b0;
    rem = 32'(slot) % plane_len;
    return (ko * ko * plane + ko * ((rem / row_len) % ko) + (rem % row_len) % ko)
           == 32'(target_reg);
  endfunction

  // Random slot for the current layout. Most land inside the layout, and a good share
  // sit exactly on the target channel, so selected results are common. The rest are
  // uniform noise and slots straddling the slot-count and plane-count edges.
  function automatic logic [SLOT_W-1:0] pick_slot();
    int unsigned ko;
    int unsigned row_len;
    int unsigned plane_len;
    int unsigned limit;
    int unsigned plane;
    int unsigned row;
    int unsigned col;
    int unsigned s;
    ko = ko_reg;
    row_len = ko * width_reg;
    plane_len = row_len * ko * height_reg;
    limit = (count_reg > MAX_SLOTS) ? MAX_SLOTS : count_reg;
    s = $urandom_range(0, 65535);
    if (plane_len != 0) begin
      case ($urandom_range(0, 9))
        0, 1: s = $urandom_range(0, 65535);
        2: s = limit + $urandom_range(0, 2) - 1;
        3: s = plane_len * planes_reg + $urandom_range(0, 2) - 1;
        4, 5, 6: begin
          plane = (planes_reg == 0) ? 0 : $urandom_range(0, planes_reg - 1);
          row = $urandom_range(0, ko * height_reg - 1);
          col = $urandom_range(0, row_len - 1);
          s = plane * plane_len + row * row_len + col;
        end
        default: begin
          // Rebuild a slot that carries the target channel from its three parts.
          plane = target_reg / (ko * ko);
          row = (target_reg % (ko * ko)) / ko + ko * $urandom_range(0, height_reg - 1);
          col = target_reg % ko + ko * $urandom_range(0, width_reg - 1);
          s = plane * plane_len + row * row_len + col;
        end
      endcase
    end
    return s[SLOT_W-1:0];
  endfunction

  // Dimension draw: mostly small, sometimes zero, sometimes the largest the field holds.
  function automatic int unsigned pick_dim(input int unsigned small_max,
                                           input int unsigned full_max);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return full_max;
      default: return $urandom_range(1, small_max);
    endcase
  endfunction

  // Now and then, set junk above a register's width; the block has to drop it.
  function automatic logic [CFG_W-1:0] with_junk(input int unsigned value,
                                                 input int unsigned bits);
    int unsigned junk;
    junk = ($urandom_range(0, 3) == 0) ? ($urandom() << bits) : 0;
    return CFG_W'(value | junk);
  endfunction

  // One register write. The data is driven at a rising edge and taken at the next one;
  // the local copy follows with the same truncation that the register applies.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      csmg_pkg::REG_GROUP_FACTOR:   ko_reg = value[KO_W-1:0];
      csmg_pkg::REG_OUT_HEIGHT:     height_reg = value[DIM_W-1:0];
      csmg_pkg::REG_OUT_WIDTH:      width_reg = value[DIM_W-1:0];
      csmg_pkg::REG_PLANE_COUNT:    planes_reg = value[DIM_W-1:0];
      csmg_pkg::REG_TARGET_CHANNEL: target_reg = value[CHAN_W-1:0];
      csmg_pkg::REG_SLOT_COUNT:     count_reg = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Block until every queued slot is accepted and every predicted result has come back.
  // Each request yields exactly one result, so the block is idle at that point.
  task automatic wait_drained();
    while (pending_slots.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic classify_one(input logic [SLOT_W-1:0] slot);
    @(negedge clk);
    pending_slots.push_back(slot);
    wait_drained();
  endtask

  // Fresh random layout with every register written, extremes included.
  task automatic shuffle_layout();
    int unsigned ko;
    int unsigned ho;
    int unsigned wo;
    int unsigned planes;
    int unsigned span;
    int unsigned target;
    int unsigned count;
    ko = pick_dim(8, 15);
    ho = pick_dim(8, 127);
    wo = pick_dim(8, 127);
    planes = pick_dim(8, 127);
    span = ko * ko * planes;
    // Usually a channel that exists in the layout, so that some slots get selected.
    if (span == 0 || $urandom_range(0, 7) == 0)
      target = $urandom_range(0, 4095);
    else
      target = $urandom_range(0, ((span > 4096) ? 4096 : span) - 1);
    case ($urandom_range(0, 7))
      0: count = 0;
      1: count = 131071;
      2: count = $urandom_range(0, 131071);
      3: count = $urandom_range(1, 4096);
      default: count = MAX_SLOTS;
    endcase
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom()));
    write_reg(csmg_pkg::REG_GROUP_FACTOR, with_junk(ko, KO_W));
    write_reg(csmg_pkg::REG_OUT_HEIGHT, with_junk(ho, DIM_W));
    write_reg(csmg_pkg::REG_OUT_WIDTH, with_junk(wo, DIM_W));
    write_reg(csmg_pkg::REG_PLANE_COUNT, with_junk(planes, DIM_W));
    write_reg(csmg_pkg::REG_TARGET_CHANNEL, with_junk(target, CHAN_W));
    write_reg(csmg_pkg::REG_SLOT_COUNT, with_junk(count, COUNT_W));
  endtask

  // A batch of random slots under the current layout. Squeeze asks the receiver for its
  // long hold-off while the sender streams back to back.
  task automatic run_batch(input int items, input bit squeeze);
    @(negedge clk);
    sender_steady = squeeze || ($urandom_range(0, 3) == 0);
    receiver_steady = ($urandom_range(0, 3) == 0);
    if (squeeze) hold_requests++;
    repeat (items) pending_slots.push_back(pick_slot());
    wait_drained();
  endtask

  // Sender. A request stays on the bus until taken; after each one a random gap is
  // drawn, unless the batch streams without gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      send_wait <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_slots.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_slots.pop_front();
        send_wait <= sender_steady ? 0 : $urandom_range(0, 9);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver and checker. Accepted requests get their prediction queued here, so the
  // queue and the comparison live in one process. After each result the receiver may
  // stall for a random stretch; on request it holds off for the long stretch counted below.
  always @(posedge clk) begin
    slot_verdict_t due;
    int unsigned pause;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
      long_hold <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due.slot = s_axis_tdata[SLOT_W-1:0];
        due.selected = predict_selected(s_axis_tdata[SLOT_W-1:0]);
        verdicts_due.push_back(due);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: slot_echo %0d selected %0d",
                 m_axis_tdata[SLOT_W-1:0], m_axis_tdata[SLOT_W]);
          mismatch_count++;
        end else begin
          due = verdicts_due.pop_front();
          if (m_axis_tdata[SLOT_W-1:0] !== due.slot) begin
            $error("slot_echo: expected %0d, actual %0d", due.slot, m_axis_tdata[SLOT_W-1:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[SLOT_W] !== due.selected) begin
            $error("selected: expected %0d, actual %0d (slot %0d)",
                   due.selected, m_axis_tdata[SLOT_W], due.slot);
            mismatch_count++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        long_hold <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (long_hold != 0) begin
        long_hold <= long_hold - 1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        pause = receiver_steady ? 0 : $urandom_range(0, 9);
        if (pause != 0) begin
          m_axis_tready <= 1'b0;
          recv_wait <= pause - 1;
        end
      end else if (!m_axis_tready) begin
        if (recv_wait != 0) recv_wait <= recv_wait - 1;
        else m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving on both sides for too long is hung.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset layout: one slot per plane and a single plane, so only slot 0 is selected.
    classify_one(16'd0);
    classify_one(16'd1);
    classify_one(16'd32768);
    classify_one(16'hFFFF);

    // Small layout: ko 2, 3 x 4 map, two planes of 48 slots, 100 slots in use.
    // Channel 5 is plane 1, even row, odd column: slots 49 and 67 among others.
    write_reg(csmg_pkg::REG_GROUP_FACTOR, 2);
    write_reg(csmg_pkg::REG_OUT_HEIGHT, 3);
    write_reg(csmg_pkg::REG_OUT_WIDTH, 4);
    write_reg(csmg_pkg::REG_PLANE_COUNT, 2);
    write_reg(csmg_pkg::REG_TARGET_CHANNEL, 5);
    write_reg(csmg_pkg::REG_SLOT_COUNT, 100);
    classify_one(16'd0);
    classify_one(16'd47);
    classify_one(16'd48);
    classify_one(16'd49);
    classify_one(16'd67);
    classify_one(16'd95);
    classify_one(16'd96);
    classify_one(16'd99);
    classify_one(16'd100);

    // Each geometry register at zero in turn empties the layout.
    write_reg(csmg_pkg::REG_GROUP_FACTOR, 0);
    classify_one(16'd49);
    write_reg(csmg_pkg::REG_GROUP_FACTOR, 2);
    write_reg(csmg_pkg::REG_OUT_HEIGHT, 0);
    classify_one(16'd49);
    write_reg(csmg_pkg::REG_OUT_HEIGHT, 3);
    write_reg(csmg_pkg::REG_OUT_WIDTH, 0);
    classify_one(16'd49);
    write_reg(csmg_pkg::REG_OUT_WIDTH, 4);
    write_reg(csmg_pkg::REG_PLANE_COUNT, 0);
    classify_one(16'd49);
    write_reg(csmg_pkg::REG_PLANE_COUNT, 2);

    // A slot count of zero selects nothing; the largest count is clipped to the maximum.
    write_reg(csmg_pkg::REG_SLOT_COUNT, 0);
    classify_one(16'd49);
    write_reg(csmg_pkg::REG_SLOT_COUNT, 17'h1FFFF);
    classify_one(16'd49);
    classify_one(16'hFFFF);

    // Writes past the register list must leave the layout as it was.
    write_reg(REG_SPARE_LO, 17'h1FFFF);
    write_reg(REG_SPARE_HI, 17'h00000);
    classify_one(16'd49);

    // Every register at its largest value.
    write_reg(csmg_pkg::REG_GROUP_FACTOR, 15);
    write_reg(csmg_pkg::REG_OUT_HEIGHT, 127);
    write_reg(csmg_pkg::REG_OUT_WIDTH, 127);
    write_reg(csmg_pkg::REG_PLANE_COUNT, 127);
    write_reg(csmg_pkg::REG_TARGET_CHANNEL, 4095);
    classify_one(16'd0);
    classify_one(16'hFFFF);

    // Random layouts. The fourth batch carries the long receiver hold-off, so the
    // pipeline backs up all the way to its input.
    for (int batch = 0; batch < 8; batch++) begin
      shuffle_layout();
      if (batch == 3) run_batch(140, 1'b1);
      else run_batch(45, 1'b0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/csmg_pkg.sv
rtl/csmg_div.sv
rtl/channel_select_mask_generator_unit.sv
tb/tb_channel_select_mask_generator_unit.sv
